[sv/dmhc_pkg.sv]
// Shared types, constants and the modulo step of the direct-mapped handle cache.
`default_nettype none

package dmhc_pkg;

    // Cache geometry
    localparam int SLOTS  = 509;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Field widths
    localparam int OP_W    = 3;
    localparam int ID_W    = 64;
    localparam int STAMP_W = 32;
    localparam int PATH_W  = 32;
    localparam int INFO_W  = 64;

    // Hash: (1999*id + 3*stamp + 5) mod 2^64, then mod SLOTS.
    // 1999 = 2^11 - 2^5 - 2^4 - 1, so the product is built from shifts.
    localparam int HASH_W    = 64;
    localparam int MUL_SH_HI = 11;
    localparam int MUL_SH_A  = 5;
    localparam int MUL_SH_B  = 4;
    localparam logic [HASH_W-1:0] HASH_ADD = 64'd5;

    // Modulo reduction walks the hash one byte per cycle, MSB first
    localparam int DIGIT_W    = 8;
    localparam int H_STEPS    = HASH_W / DIGIT_W;
    localparam int STEP_CNT_W = $clog2(H_STEPS);

    typedef enum logic [OP_W-1:0] {
        OP_STORE_PATH = 3'd0,
        OP_STORE_INFO = 3'd1,
        OP_GET_PATH   = 3'd2,
        OP_GET_INFO   = 3'd3,
        OP_INVALIDATE = 3'd4
    } op_t;

    typedef struct packed {
        logic                valid;
        logic                path_valid;
        logic                info_valid;
        logic [ID_W-1:0]     key_id;
        logic [STAMP_W-1:0]  key_stamp;
        logic [PATH_W-1:0]   path;
        logic [INFO_W-1:0]   info;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic hash_a;
        logic hash_b;
        logic reduce;
        logic ram_rd;
        logic commit;
        logic clear_wr;
    } dmhc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_invalidate;
        logic clear_last;
    } dmhc_status_t;

    // Shift one byte into a running remainder modulo SLOTS, one bit at a time
    function automatic logic [SLOT_W-1:0] mod_digit(input logic [SLOT_W-1:0] rem,
                                                    input logic [DIGIT_W-1:0] digit);
        logic [SLOT_W:0]   t;
        logic [SLOT_W-1:0] r;
        r = rem;
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            t = {r, digit[i]};
            if (t >= (SLOT_W + 1)'(SLOTS)) begin
                t = t - (SLOT_W + 1)'(SLOTS);
            end
            r = t[SLOT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/dmhc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dmhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [ADDR_W-1:0]        waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [ADDR_W-1:0]        raddr,
    output      logic [WIDTH-1:0]         rdata
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, read port; read data holds until the next read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/dmhc_datapath.sv]
// Datapath: request capture, slot hash, modulo reduction, entry memory and result register.
`default_nettype none

module dmhc_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire dmhc_pkg::dmhc_cmd_t          cmd_i,
    output      dmhc_pkg::dmhc_status_t       status_o,
    input  wire logic [dmhc_pkg::OP_W-1:0]    op_i,
    input  wire logic [dmhc_pkg::ID_W-1:0]    key_id_i,
    input  wire logic [dmhc_pkg::STAMP_W-1:0] key_stamp_i,
    input  wire logic [dmhc_pkg::PATH_W-1:0]  path_ref_i,
    input  wire logic [dmhc_pkg::INFO_W-1:0]  info_word_i,
    output      logic                         hit_o,
    output      logic [dmhc_pkg::PATH_W-1:0]  path_out_o,
    output      logic [dmhc_pkg::INFO_W-1:0]  info_out_o
);

    // Captured request
    logic [dmhc_pkg::OP_W-1:0]    op_reg;
    logic [dmhc_pkg::ID_W-1:0]    key_id_reg;
    logic [dmhc_pkg::STAMP_W-1:0] key_stamp_reg;
    logic [dmhc_pkg::PATH_W-1:0]  path_ref_reg;
    logic [dmhc_pkg::INFO_W-1:0]  info_word_reg;

    // Hash pipeline
    logic [dmhc_pkg::HASH_W-1:0]  part_a_reg;
    logic [dmhc_pkg::HASH_W-1:0]  part_b_reg;
    logic [dmhc_pkg::HASH_W-1:0]  part_c_reg;
    logic [dmhc_pkg::HASH_W-1:0]  hash_reg;
    logic [dmhc_pkg::SLOT_W-1:0]  rem_reg;

    // Clearing sweep address
    logic [dmhc_pkg::SLOT_W-1:0]  clr_addr_reg;

    // Result register
    logic                         hit_reg;
    logic [dmhc_pkg::PATH_W-1:0]  path_out_reg;
    logic [dmhc_pkg::INFO_W-1:0]  info_out_reg;

    // Memory ports
    dmhc_pkg::entry_t             rd_entry;
    dmhc_pkg::entry_t             new_entry;
    logic [dmhc_pkg::ENTRY_W-1:0] rd_data;
    logic [dmhc_pkg::ENTRY_W-1:0] wr_data;
    logic [dmhc_pkg::SLOT_W-1:0]  wr_addr;
    logic                         wr_en;

    // Response of the current request
    logic                         key_match;
    logic                         is_store;
    logic                         resp_hit;
    logic [dmhc_pkg::PATH_W-1:0]  resp_path;
    logic [dmhc_pkg::INFO_W-1:0]  resp_info;

    // Capture the request and run the hash and reduction steps
    always_ff @(posedge aclk) begin
        if (cmd_i.capture) begin
            op_reg        <= op_i;
            key_id_reg    <= key_id_i;
            key_stamp_reg <= key_stamp_i;
            path_ref_reg  <= path_ref_i;
            info_word_reg <= info_word_i;
        end
        if (cmd_i.hash_a) begin
            part_a_reg <= (key_id_reg << dmhc_pkg::MUL_SH_HI)
                        - (key_id_reg << dmhc_pkg::MUL_SH_A);
            part_b_reg <= (key_id_reg << dmhc_pkg::MUL_SH_B) + key_id_reg;
            part_c_reg <= (dmhc_pkg::HASH_W'(key_stamp_reg) << 1)
                        + dmhc_pkg::HASH_W'(key_stamp_reg) + dmhc_pkg::HASH_ADD;
        end
        if (cmd_i.hash_b) begin
            hash_reg <= part_a_reg - part_b_reg + part_c_reg;
            rem_reg  <= '0;
        end
        if (cmd_i.reduce) begin
            rem_reg  <= dmhc_pkg::mod_digit(rem_reg,
                            hash_reg[dmhc_pkg::HASH_W-1 -: dmhc_pkg::DIGIT_W]);
            hash_reg <= hash_reg << dmhc_pkg::DIGIT_W;
        end
        if (cmd_i.commit) begin
            hit_reg      <= resp_hit;
            path_out_reg <= resp_path;
            info_out_reg <= resp_info;
        end
    end

    // Advance the sweep address, wrap after the last slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd_i.clear_wr) begin
            if (status_o.clear_last) begin
                clr_addr_reg <= '0;
            end else begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    assign status_o.is_invalidate = (op_reg == dmhc_pkg::OP_INVALIDATE);
    assign status_o.clear_last    = (clr_addr_reg == dmhc_pkg::SLOT_W'(dmhc_pkg::SLOTS - 1));

    assign rd_entry  = dmhc_pkg::entry_t'(rd_data);
    assign key_match = rd_entry.valid && (rd_entry.key_id == key_id_reg)
                       && (rd_entry.key_stamp == key_stamp_reg);

    // Work out the result and the updated entry
    always_comb begin
        new_entry = rd_entry;
        is_store  = 1'b0;
        resp_hit  = 1'b0;
        resp_path = '0;
        resp_info = '0;
        unique case (op_reg)
            dmhc_pkg::OP_STORE_PATH: begin
                is_store = 1'b1;
                if (!key_match) begin
                    new_entry.valid      = 1'b1;
                    new_entry.info_valid = 1'b0;
                    new_entry.key_id     = key_id_reg;
                    new_entry.key_stamp  = key_stamp_reg;
                end
                new_entry.path_valid = 1'b1;
                new_entry.path       = path_ref_reg;
            end
            dmhc_pkg::OP_STORE_INFO: begin
                is_store = 1'b1;
                resp_hit = key_match;
                if (!key_match) begin
                    new_entry.valid      = 1'b1;
                    new_entry.path_valid = 1'b0;
                    new_entry.key_id     = key_id_reg;
                    new_entry.key_stamp  = key_stamp_reg;
                    new_entry.path       = '0;
                end
                new_entry.info_valid = 1'b1;
                new_entry.info       = info_word_reg;
            end
            dmhc_pkg::OP_GET_PATH: begin
                if (key_match && rd_entry.path_valid) begin
                    resp_hit  = 1'b1;
                    resp_path = rd_entry.path;
                end
            end
            dmhc_pkg::OP_GET_INFO: begin
                if (key_match && rd_entry.info_valid) begin
                    resp_hit  = 1'b1;
                    resp_info = rd_entry.info;
                end
            end
            default: begin
                // invalidate and unused codes: all-zero result, no write here
            end
        endcase
    end

    // Sweep writes take the port over a request's write-back
    assign wr_en   = cmd_i.clear_wr || (cmd_i.commit && is_store);
    assign wr_addr = cmd_i.clear_wr ? clr_addr_reg : rem_reg;
    assign wr_data = cmd_i.clear_wr ? '0 : dmhc_pkg::ENTRY_W'(new_entry);

    dmhc_ram #(
        .WIDTH (dmhc_pkg::ENTRY_W),
        .DEPTH (dmhc_pkg::SLOTS)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (cmd_i.ram_rd),
        .raddr (rem_reg),
        .rdata (rd_data)
    );

    assign hit_o      = hit_reg;
    assign path_out_o = path_out_reg;
    assign info_out_o = info_out_reg;

    // Slot index stays inside the table
    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.ram_rd |-> ({1'b0, rem_reg} < (dmhc_pkg::SLOT_W + 1)'(dmhc_pkg::SLOTS)))
        else $error("slot index out of range");

    a_sweep_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.clear_wr |-> ({1'b0, clr_addr_reg} < (dmhc_pkg::SLOT_W + 1)'(dmhc_pkg::SLOTS)))
        else $error("sweep address out of range");

    // A miss never returns data
    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.commit |=> (hit_reg || (path_out_reg == '0 && info_out_reg == '0)))
        else $error("data returned without a hit");

endmodule

`default_nettype wire

[sv/dmhc_ctrl.sv]
// Controller: sequences capture, hash, reduction, memory access, sweeps and result hand-off.
`default_nettype none

module dmhc_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      dmhc_pkg::dmhc_cmd_t    cmd_o,
    input  wire dmhc_pkg::dmhc_status_t status_i
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH_A,
        ST_HASH_B,
        ST_REDUCE,
        ST_READ,
        ST_RESP,
        ST_SWEEP,
        ST_SWEEP_INIT
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic                            m_tvalid_reg;
    logic                            m_tvalid_next;
    logic [dmhc_pkg::STEP_CNT_W-1:0] step_cnt_reg;
    logic [dmhc_pkg::STEP_CNT_W-1:0] step_cnt_next;
    logic                            out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd_o         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_o.capture = 1'b1;
                    state_next    = ST_HASH_A;
                end
            end
            ST_HASH_A: begin
                if (status_i.is_invalidate) begin
                    state_next = ST_SWEEP;
                end else begin
                    cmd_o.hash_a = 1'b1;
                    state_next   = ST_HASH_B;
                end
            end
            ST_HASH_B: begin
                cmd_o.hash_b  = 1'b1;
                step_cnt_next = '0;
                state_next    = ST_REDUCE;
            end
            ST_REDUCE: begin
                cmd_o.reduce = 1'b1;
                if (step_cnt_reg == dmhc_pkg::STEP_CNT_W'(dmhc_pkg::H_STEPS - 1)) begin
                    state_next = ST_READ;
                end else begin
                    step_cnt_next = step_cnt_reg + 1'b1;
                end
            end
            ST_READ: begin
                cmd_o.ram_rd = 1'b1;
                state_next   = ST_RESP;
            end
            ST_RESP: begin
                // hold the finished request until the result register frees
                if (out_free) begin
                    cmd_o.commit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                cmd_o.clear_wr = 1'b1;
                if (status_i.clear_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_SWEEP_INIT: begin
                cmd_o.clear_wr = 1'b1;
                if (status_i.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        priority if (cmd_o.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP_INIT;
            m_tvalid_reg <= 1'b0;
            step_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // A result appears only after a commit
    a_valid_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(cmd_o.commit))
        else $error("result valid without a commit");

    // Never overwrite a result still waiting to be taken
    a_commit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.commit |-> out_free)
        else $error("commit over a pending result");

    // No request taken while the table is being cleared
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.clear_wr |-> (!s_tready && !cmd_o.commit && !cmd_o.ram_rd))
        else $error("request activity during a sweep");

endmodule

`default_nettype wire

[sv/direct_mapped_handle_cache.sv]
// Top level of the direct-mapped handle cache: controller, datapath and stream ports.
// Direct-mapped cache of SLOTS entries keyed by a 64-bit id and a 32-bit stamp; each
// request picks slot (1999*id + 3*stamp + 5) mod SLOTS, the sum wrapping at 64 bits.
// One request is in flight at a time. A store or get runs from acceptance to result
// through the accept step, the hash steps, the modulo walk (one byte of the hash per
// step), the memory read and the response with write-back; the modulo walk dominates.
// Invalidate all is dominated by the sweep that writes one cleared entry per cycle
// through the single memory write port. After reset the same sweep runs before the
// first request is accepted. The result register lets a result wait on m_tready while
// the next request is being worked.
`default_nettype none

module direct_mapped_handle_cache (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // request channel
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    input  wire logic [191:0] s_tdata,  // key_id[63:0], key_stamp[95:64], path_ref[127:96],
                                        // info_word[191:128]
    input  wire logic [2:0]   s_tuser,  // operation[2:0]
    // result channel
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    output      logic [95:0]  m_tdata,  // path_out[31:0], info_out[95:32]
    output      logic [0:0]   m_tuser   // hit[0]
);

    dmhc_pkg::dmhc_cmd_t    cmd;
    dmhc_pkg::dmhc_status_t status;
    logic                   hit;
    logic [dmhc_pkg::PATH_W-1:0] path_out;
    logic [dmhc_pkg::INFO_W-1:0] info_out;

    dmhc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd_o    (cmd),
        .status_i (status)
    );

    dmhc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_i       (cmd),
        .status_o    (status),
        .op_i        (s_tuser),
        .key_id_i    (s_tdata[63:0]),
        .key_stamp_i (s_tdata[95:64]),
        .path_ref_i  (s_tdata[127:96]),
        .info_word_i (s_tdata[191:128]),
        .hit_o       (hit),
        .path_out_o  (path_out),
        .info_out_o  (info_out)
    );

    // Pack the result
    assign m_tdata = {info_out, path_out};
    assign m_tuser = hit;

endmodule

`default_nettype wire

[tb/dmhc_checker.sv]
// Monitor, cache predictor and result scoreboard for the direct-mapped handle cache.
module dmhc_checker
    import dmhc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [191:0] s_tdata,  // key_id[63:0], key_stamp[95:64], path_ref[127:96],
                                        // info_word[191:128]
    input  wire logic [2:0]   s_tuser,  // operation[2:0]
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [95:0]  m_tdata,  // path_out[31:0], info_out[95:32]
    input  wire logic [0:0]   m_tuser,  // hit[0]
    output int                error_count,
    output int                results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              hit;
        logic [PATH_W-1:0] path;
        logic [INFO_W-1:0] info;
    } lookup_result_t;

    // Slot hash: (1999*id + 3*stamp + 5) wrapping at 64 bits, then mod SLOTS
    localparam logic [HASH_W-1:0] ID_MULT     = 64'd1999;
    localparam logic [HASH_W-1:0] STAMP_MULT  = 64'd3;
    localparam logic [HASH_W-1:0] HASH_OFFSET = 64'd5;
    localparam logic [HASH_W-1:0] SLOT_COUNT  = HASH_W'(SLOTS);

    // Shadow copy of the cache contents
    logic               entry_valid [SLOTS];
    logic               path_valid  [SLOTS];
    logic               info_valid  [SLOTS];
    logic [ID_W-1:0]    entry_id    [SLOTS];
    logic [STAMP_W-1:0] entry_stamp [SLOTS];
    logic [PATH_W-1:0]  entry_path  [SLOTS];
    logic [INFO_W-1:0]  entry_info  [SLOTS];

    lookup_result_t expected_results [$];
    int             mismatches = 0;

    function automatic int slot_index(input logic [ID_W-1:0] id,
                                      input logic [STAMP_W-1:0] stamp);
        logic [HASH_W-1:0] h;
        h = id * ID_MULT + HASH_W'(stamp) * STAMP_MULT + HASH_OFFSET;
        return int'(h % SLOT_COUNT);
    endfunction

    // Apply one request to the shadow cache and return the result it should give
    function automatic lookup_result_t apply_request(input logic [OP_W-1:0]    code,
                                                     input logic [ID_W-1:0]    id,
                                                     input logic [STAMP_W-1:0] stamp,
                                                     input logic [PATH_W-1:0]  path_word,
                                                     input logic [INFO_W-1:0]  info_val);
        int             s;
        logic           same_key;
        lookup_result_t r;
        s        = slot_index(id, stamp);
        same_key = entry_valid[s] && entry_id[s] == id && entry_stamp[s] == stamp;
        r        = '0;
        case (code)
            OP_STORE_PATH: begin
                // a foreign or empty slot takes the new key and loses its info
                if (!same_key) begin
                    entry_valid[s] = 1'b1;
                    info_valid[s]  = 1'b0;
                    entry_id[s]    = id;
                    entry_stamp[s] = stamp;
                end
                path_valid[s] = 1'b1;
                entry_path[s] = path_word;
            end
            OP_STORE_INFO: begin
                // a new entry starts with its path cleared
                if (same_key) begin
                    r.hit = 1'b1;
                end else begin
                    entry_valid[s] = 1'b1;
                    path_valid[s]  = 1'b0;
                    entry_id[s]    = id;
                    entry_stamp[s] = stamp;
                    entry_path[s]  = '0;
                end
                info_valid[s] = 1'b1;
                entry_info[s] = info_val;
            end
            OP_GET_PATH: begin
                if (same_key && path_valid[s]) begin
                    r.hit  = 1'b1;
                    r.path = entry_path[s];
                end
            end
            OP_GET_INFO: begin
                if (same_key && info_valid[s]) begin
                    r.hit  = 1'b1;
                    r.info = entry_info[s];
                end
            end
            OP_INVALIDATE: begin
                for (int k = 0; k < SLOTS; k++) begin
                    entry_valid[k] = 1'b0;
                    path_valid[k]  = 1'b0;
                    info_valid[k]  = 1'b0;
                    entry_id[k]    = '0;
                    entry_stamp[k] = '0;
                end
            end
            default: begin
                // unused codes leave the cache alone and answer with zeros
            end
        endcase
        return r;
    endfunction

    // Predict on every accepted request, compare every accepted result
    always @(posedge aclk) begin : monitor
        lookup_result_t seen;
        lookup_result_t want;
        if (!aresetn) begin
            for (int k = 0; k < SLOTS; k++) begin
                entry_valid[k] = 1'b0;
                path_valid[k]  = 1'b0;
                info_valid[k]  = 1'b0;
            end
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_request(s_tuser, s_tdata[63:0],
                                                         s_tdata[95:64], s_tdata[127:96],
                                                         s_tdata[191:128]));
            end
            if (m_tvalid && m_tready) begin
                seen = {m_tuser[0], m_tdata[31:0], m_tdata[95:32]};
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no request pending: hit %0d path %h info %h",
                             $time, seen.hit, seen.path, seen.info);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (seen.hit !== want.hit) begin
                        $display("%0t: hit mismatch, expected %0d, actual %0d",
                                 $time, want.hit, seen.hit);
                        mismatches++;
                    end
                    if (seen.path !== want.path) begin
                        $display("%0t: path_out mismatch, expected %h, actual %h",
                                 $time, want.path, seen.path);
                        mismatches++;
                    end
                    if (seen.info !== want.info) begin
                        $display("%0t: info_out mismatch, expected %h, actual %h",
                                 $time, want.info, seen.info);
                        mismatches++;
                    end
                end
            end
        end
        error_count     <= mismatches;
        results_pending <= expected_results.size();
    end

endmodule

[tb/tb_top.sv]
// Testbench top for the direct-mapped handle cache: clock, reset, request traffic and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dmhc_pkg::*;

    localparam int RANDOM_REQUESTS = 1050;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = SLOTS + 20;
    localparam int KEY_POOL        = 16;

    // Operation codes the block ignores
    localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

    // Keys for the directed part; the collide key shares the slot of the zero key
    localparam logic [ID_W-1:0]    ID_ZERO       = '0;
    localparam logic [ID_W-1:0]    ID_ONES       = '1;
    localparam logic [STAMP_W-1:0] STAMP_ZERO    = '0;
    localparam logic [STAMP_W-1:0] STAMP_ONES    = '1;
    localparam logic [STAMP_W-1:0] STAMP_COLLIDE = STAMP_W'(SLOTS);

    typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_TOGGLE} ready_mode_e;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [191:0] s_tdata  = '0;
    logic [2:0]   s_tuser  = '0;
    logic         m_tready = 1'b0;
    logic         s_tready;
    logic         m_tvalid;
    logic [95:0]  m_tdata;
    logic [0:0]   m_tuser;
    int           error_count;
    int           results_pending;
    logic         hold_off_req = 1'b0;
    int           burst_left   = 0;

    logic [ID_W-1:0]    pool_id    [KEY_POOL] = '{default: '0};
    logic [STAMP_W-1:0] pool_stamp [KEY_POOL] = '{default: '0};

    direct_mapped_handle_cache u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    dmhc_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // Offer one request, often idling first when a burst has run out; return once accepted
    task automatic send_request(input logic [OP_W-1:0]    op,
                                input logic [ID_W-1:0]    id,
                                input logic [STAMP_W-1:0] stamp,
                                input logic [PATH_W-1:0]  path_word,
                                input logic [INFO_W-1:0]  info_val);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {info_val, path_word, stamp, id};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the request side until every outstanding result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    // Fill one key pool entry, often on the slot of another entry
    task automatic make_key(input int idx);
        int partner;
        partner = $urandom_range(0, KEY_POOL - 1);
        if (partner != idx && $urandom_range(0, 1)) begin
            // moving id or stamp by SLOTS keeps the slot unless the sum wraps
            pool_id[idx]    = pool_id[partner];
            pool_stamp[idx] = pool_stamp[partner];
            if ($urandom_range(0, 1)) pool_id[idx] = pool_id[idx] + ID_W'(SLOTS);
            else pool_stamp[idx] = pool_stamp[idx] + STAMP_W'(SLOTS);
        end else begin
            pool_id[idx]    = $urandom_range(0, 1) ? {$urandom, $urandom}
                                                   : ID_W'($urandom_range(0, 1023));
            pool_stamp[idx] = $urandom_range(0, 1) ? $urandom
                                                   : STAMP_W'($urandom_range(0, 1023));
        end
    endtask

    // Receiver: ready pattern in random segments, plus one long hold-off
    initial begin
        ready_mode_e mode;
        int          seg_left;
        bit          hold_done;
        mode      = READY_ALWAYS;
        seg_left  = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                if (seg_left == 0) begin
                    mode     = ready_mode_e'($urandom_range(0, 3));
                    seg_left = $urandom_range(16, 256);
                end
                seg_left--;
                case (mode)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:      m_tready <= ~m_tready;
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int                 sent;
        int                 roll;
        int                 k;
        bit                 paused;
        logic [OP_W-1:0]    op;
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] stamp;
        while (!aresetn) @(posedge aclk);
        @(posedge aclk);

        // Directed: empty misses, partial entries, matches, replacement, clearing
        send_request(OP_GET_PATH,   ID_ZERO, STAMP_ZERO,    '0, '0);
        send_request(OP_GET_INFO,   ID_ZERO, STAMP_ZERO,    '0, '0);
        send_request(OP_STORE_PATH, ID_ZERO, STAMP_ZERO,    '1, '0);
        send_request(OP_GET_PATH,   ID_ZERO, STAMP_ZERO,    '0, '0);
        send_request(OP_GET_INFO,   ID_ZERO, STAMP_ZERO,    '0, '0);
        send_request(OP_STORE_INFO, ID_ZERO, STAMP_ZERO,    '0, '1);
        send_request(OP_GET_INFO,   ID_ZERO, STAMP_ZERO,    '1, '0);
        send_request(OP_STORE_PATH, ID_ZERO, STAMP_COLLIDE, '0, '1);
        send_request(OP_GET_PATH,   ID_ZERO, STAMP_ZERO,    '0, '0);
        send_request(OP_GET_INFO,   ID_ZERO, STAMP_COLLIDE, '0, '0);
        send_request(OP_STORE_INFO, ID_ONES, STAMP_ONES,    '1, '0);
        send_request(OP_GET_PATH,   ID_ONES, STAMP_ONES,    '0, '0);
        send_request(OP_GET_INFO,   ID_ONES, STAMP_ONES,    '0, '0);
        send_request(OP_STORE_PATH, ID_ONES, STAMP_ONES,    32'hA5A5_5A5A, '0);
        send_request(OP_GET_PATH,   ID_ONES, STAMP_ONES,    '0, '1);
        send_request(OP_STORE_INFO, ID_ZERO, STAMP_COLLIDE, '0, 64'h0123_4567_89AB_CDEF);
        send_request(OP_STORE_INFO, ID_ZERO, STAMP_ZERO,    '0, 64'hFEDC_BA98_7654_3210);
        send_request(OP_GET_PATH,   ID_ZERO, STAMP_ZERO,    '0, '0);
        send_request(OP_GET_INFO,   ID_ZERO, STAMP_ZERO,    '0, '0);
        for (int c = OP_RESERVED_FIRST; c <= OP_RESERVED_LAST; c++) begin
            send_request(OP_W'(c), ID_ONES, STAMP_ONES, '1, '1);
        end
        send_request(OP_INVALIDATE, ID_ONES, STAMP_ONES,    '1, '1);
        send_request(OP_GET_INFO,   ID_ZERO, STAMP_ZERO,    '0, '0);
        send_request(OP_GET_PATH,   ID_ONES, STAMP_ONES,    '0, '0);
        wait_drained();

        // Random: mostly traffic on a small key pool so entries hit, collide and age
        for (int i = 0; i < KEY_POOL; i++) make_key(i);
        hold_off_req <= 1'b1;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_REQUESTS) begin
            roll  = $urandom_range(0, 999);
            k     = $urandom_range(0, KEY_POOL - 1);
            if (roll >= 980) make_key(k);
            id    = pool_id[k];
            stamp = pool_stamp[k];
            if ($urandom_range(0, 19) == 0) begin
                // stray key, almost never cached
                id    = {$urandom, $urandom};
                stamp = $urandom;
            end
            if (roll < 250)      op = OP_STORE_PATH;
            else if (roll < 500) op = OP_STORE_INFO;
            else if (roll < 720) op = OP_GET_PATH;
            else if (roll < 950) op = OP_GET_INFO;
            else if (roll < 960) op = OP_INVALIDATE;
            else if (roll < 980) op = OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
            else                 op = OP_STORE_INFO;
            send_request(op, id, stamp, $urandom, {$urandom, $urandom});
            if (op <= OP_INVALIDATE) sent++;
            if (!paused && sent >= RANDOM_REQUESTS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        // Drain, let any stray result surface, then judge
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && results_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
